>>> rtl/cpu_job_scheduler_unit_assert.svh
// assertion macros for the job scheduler
`ifndef CPU_JOB_SCHEDULER_UNIT_ASSERT_SVH
`define CPU_JOB_SCHEDULER_UNIT_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define CJS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define CJS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> rtl/cjs_pkg.sv
`default_nettype none
package cjs_pkg;
    localparam int QueueDepth = 16;
    localparam int CntW = $clog2(QueueDepth + 1);

    localparam logic [1:0] POLICY_FIFO = 2'd0;
    localparam logic [1:0] POLICY_PRIO = 2'd1;
    localparam logic [1:0] POLICY_SJF  = 2'd2;

    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [1:0] REG_POLICY  = 2'd0;
    localparam logic [1:0] REG_QEN     = 2'd1;
    localparam logic [1:0] REG_PEN     = 2'd2;
    localparam logic [1:0] REG_QLEN    = 2'd3;

    typedef struct packed {
        logic [7:0]  id;
        logic [7:0]  prio;
        logic [15:0] dur;
        logic [15:0] rem;
        logic [15:0] age;
    } job_t;

    // command broadcast to every queue cell
    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_POP,
        CMD_AGE
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [1:0] policy;
        job_t       job;
    } cell_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_REINSERT,
        ST_AGE,
        ST_RETIRE,
        ST_OUT
    } state_t;

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        sat_inc16 = (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction
endpackage
`default_nettype wire

>>> rtl/cjs_if.sv
`default_nettype none
interface cjs_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [7:0]  job_id;
    logic [15:0] duration;
    logic [7:0]  job_priority;
    modport source (output valid, opcode, job_id, duration, job_priority, input ready);
    modport sink (input valid, opcode, job_id, duration, job_priority, output ready);
endinterface

interface cjs_out_if;
    logic        valid;
    logic        ready;
    logic        running_valid;
    logic [7:0]  running_id;
    logic        done_valid;
    logic [7:0]  done_id;
    logic [15:0] done_turnaround;
    logic        overflow;
    modport source (output valid, running_valid, running_id, done_valid, done_id,
                    done_turnaround, overflow, input ready);
    modport sink (input valid, running_valid, running_id, done_valid, done_id,
                  done_turnaround, overflow, output ready);
endinterface
`default_nettype wire

>>> rtl/cjs_cell.sv
`default_nettype none
module cjs_cell
    import cjs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_ctl_t ctl,
    input  wire logic      prev_valid,
    input  wire job_t      prev_job,
    input  wire logic      prev_takes,
    input  wire logic      next_valid,
    input  wire job_t      next_job,
    output logic           valid,
    output job_t           job,
    output logic           takes
);
    logic valid_reg, valid_next;
    job_t job_reg, job_next;
    logic beats;

    // new job goes ahead of this entry
    always_comb
    begin
        unique case (ctl.policy)
            POLICY_PRIO: beats = ctl.job.prio > job_reg.prio;
            POLICY_SJF:  beats = ctl.job.dur < job_reg.dur;
            default:     beats = 1'b0;
        endcase
        takes = !valid_reg || beats;
    end

    always_comb
    begin
        valid_next = valid_reg;
        job_next   = job_reg;
        unique case (ctl.cmd)
            CMD_INSERT:
            begin
                if (takes)
                begin
                    if (prev_takes)
                    begin
                        job_next   = prev_job;
                        valid_next = prev_valid;
                    end
                    else
                    begin
                        job_next   = ctl.job;
                        valid_next = 1'b1;
                    end
                end
            end
            CMD_POP:
            begin
                job_next   = next_job;
                valid_next = next_valid;
            end
            CMD_AGE:
            begin
                job_next.age = sat_inc16(job_reg.age);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    assign valid = valid_reg;
    assign job   = job_reg;
endmodule
`default_nettype wire

>>> rtl/cjs_queue.sv
`default_nettype none
module cjs_queue
    import cjs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_ctl_t ctl,
    output logic           head_valid,
    output job_t           head_job,
    output logic           full
);
    logic [QueueDepth-1:0] v;
    logic [QueueDepth-1:0] tk;
    job_t                  j [QueueDepth];

    for (genvar g = 0; g < QueueDepth; g++)
    begin : g_cell
        logic pv, pt, nv;
        job_t pj, nj;
        if (g == 0)
        begin : g_first
            assign pv = 1'b0;
            assign pj = ctl.job;
            assign pt = 1'b0;
        end
        else
        begin : g_mid
            assign pv = v[g-1];
            assign pj = j[g-1];
            assign pt = tk[g-1];
        end
        if (g == QueueDepth - 1)
        begin : g_last
            assign nv = 1'b0;
            assign nj = j[g];
        end
        else
        begin : g_rest
            assign nv = v[g+1];
            assign nj = j[g+1];
        end
        cjs_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .prev_valid (pv),
            .prev_job   (pj),
            .prev_takes (pt),
            .next_valid (nv),
            .next_job   (nj),
            .valid      (v[g]),
            .job        (j[g]),
            .takes      (tk[g])
        );
    end

    assign head_valid = v[0];
    assign head_job   = j[0];
    assign full       = v[QueueDepth-1];
endmodule
`default_nettype wire

>>> rtl/cpu_job_scheduler_unit.sv
`default_nettype none
// cpu job scheduler: one core, one ready queue kept in a chain of cells
// in channel carries words: opcode 0 arrives a job, opcode 1 is a tick
// out channel returns exactly one word per input word
// arrive: the new job ripples into its sorted slot on a single insert
//   command unless the queue is full; steps: accept, insert, output
// tick: dispatch/preempt, optional reinsert of the displaced job, age,
//   retire/requeue, then output
// the queue cells take one broadcast command per cycle
// one word is in flight at a time; in.ready is high only when idle
// a new word can be taken in the cycle after its result leaves
// the result sits in an output register until out.ready takes it, a stalled
//   receiver holds the block idle with no loss
// reset empties the queue and core, policy fifo, quantum length 2
// configuration writes are taken at any time the write enable is high
`include "cpu_job_scheduler_unit_assert.svh"
module cpu_job_scheduler_unit
    import cjs_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    cjs_in_if.sink      in_ch,
    cjs_out_if.source   out_ch,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);
    state_t state_reg, state_next;

    logic [1:0] policy_reg;
    logic       qen_reg, pen_reg;
    logic [7:0] qlen_reg;

    logic       run_valid_reg, run_valid_next;
    job_t       run_reg, run_next;
    logic [7:0] qcnt_reg, qcnt_next;
    job_t       old_reg, old_next;
    logic [CntW-1:0] cnt_reg, cnt_next;

    logic        out_valid_reg, out_valid_next;
    logic        o_rv_reg, o_rv_next, o_dv_reg, o_dv_next, o_ovf_reg, o_ovf_next;
    logic [7:0]  o_rid_reg, o_rid_next, o_did_reg, o_did_next;
    logic [15:0] o_ta_reg, o_ta_next;

    logic        in_job_sel_reg;
    job_t        arr_reg;

    cell_ctl_t ctl;
    logic      head_valid, full;
    job_t      head_job;

    cjs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .head_valid (head_valid),
        .head_job   (head_job),
        .full       (full)
    );

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POLICY_FIFO;
            qen_reg    <= 1'b0;
            pen_reg    <= 1'b0;
            qlen_reg   <= 8'd2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POLICY: policy_reg <= cfg_data[1:0];
                REG_QEN:    qen_reg    <= cfg_data[0];
                REG_PEN:    pen_reg    <= cfg_data[0];
                REG_QLEN:   qlen_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_ch.ready = (state_reg == ST_IDLE) && !out_valid_reg;

    // latch the arriving word
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            arr_reg.id     <= in_ch.job_id;
            arr_reg.prio   <= in_ch.job_priority;
            arr_reg.dur    <= in_ch.duration;
            arr_reg.rem    <= in_ch.duration;
            arr_reg.age    <= 16'd0;
            in_job_sel_reg <= in_ch.opcode;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        run_valid_next = run_valid_reg;
        run_next       = run_reg;
        qcnt_next      = qcnt_reg;
        old_next       = old_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        o_rv_next      = o_rv_reg;
        o_rid_next     = o_rid_reg;
        o_dv_next      = o_dv_reg;
        o_did_next     = o_did_reg;
        o_ta_next      = o_ta_reg;
        o_ovf_next     = o_ovf_reg;
        ctl.cmd        = CMD_HOLD;
        ctl.policy     = policy_reg;
        ctl.job        = arr_reg;

        if (out_valid_reg && out_ch.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    o_rv_next  = 1'b0;
                    o_rid_next = 8'd0;
                    o_dv_next  = 1'b0;
                    o_did_next = 8'd0;
                    o_ta_next  = 16'd0;
                    o_ovf_next = 1'b0;
                    state_next = (in_ch.opcode == OP_TICK) ? ST_DISPATCH : ST_OUT;
                    if (in_ch.opcode == OP_ARRIVE)
                        state_next = ST_REINSERT;
                end
            end
            ST_REINSERT:
            begin
                // arrival insert or displaced-job reinsert
                if (in_job_sel_reg == OP_ARRIVE)
                begin
                    if (full)
                        o_ovf_next = 1'b1;
                    else
                    begin
                        ctl.cmd  = CMD_INSERT;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    state_next = ST_OUT;
                end
                else
                begin
                    ctl.cmd    = CMD_INSERT;
                    ctl.job    = old_reg;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_AGE;
                end
            end
            ST_DISPATCH:
            begin
                state_next = ST_AGE;
                if (!run_valid_reg)
                begin
                    if (head_valid)
                    begin
                        ctl.cmd        = CMD_POP;
                        cnt_next       = cnt_reg - 1'b1;
                        run_next       = head_job;
                        run_valid_next = 1'b1;
                        qcnt_next      = 8'd0;
                    end
                end
                else if (pen_reg && head_valid && head_job.prio > run_reg.prio)
                begin
                    ctl.cmd    = CMD_POP;
                    cnt_next   = cnt_reg - 1'b1;
                    old_next   = run_reg;
                    run_next   = head_job;
                    qcnt_next  = 8'd0;
                    state_next = ST_REINSERT;
                end
            end
            ST_AGE:
            begin
                ctl.cmd = CMD_AGE;
                if (run_valid_reg)
                begin
                    o_rv_next    = 1'b1;
                    o_rid_next   = run_reg.id;
                    run_next.age = sat_inc16(run_reg.age);
                    if (run_reg.rem != 16'd0)
                        run_next.rem = run_reg.rem - 16'd1;
                    if (qcnt_reg != 8'hFF)
                        qcnt_next = qcnt_reg + 8'd1;
                end
                state_next = ST_RETIRE;
            end
            ST_RETIRE:
            begin
                if (run_valid_reg)
                begin
                    if (run_reg.rem == 16'd0)
                    begin
                        o_dv_next      = 1'b1;
                        o_did_next     = run_reg.id;
                        o_ta_next      = run_reg.age;
                        run_valid_next = 1'b0;
                        qcnt_next      = 8'd0;
                    end
                    else if (qen_reg && qcnt_reg >= qlen_reg)
                    begin
                        if (!full)
                        begin
                            ctl.cmd        = CMD_INSERT;
                            ctl.job        = run_reg;
                            cnt_next       = cnt_reg + 1'b1;
                            run_valid_next = 1'b0;
                        end
                        qcnt_next = 8'd0;
                    end
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            run_valid_reg <= 1'b0;
            qcnt_reg      <= 8'd0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_valid_reg <= run_valid_next;
            qcnt_reg      <= qcnt_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg   <= run_next;
        old_reg   <= old_next;
        o_rv_reg  <= o_rv_next;
        o_rid_reg <= o_rid_next;
        o_dv_reg  <= o_dv_next;
        o_did_reg <= o_did_next;
        o_ta_reg  <= o_ta_next;
        o_ovf_reg <= o_ovf_next;
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.running_valid   = o_rv_reg;
    assign out_ch.running_id      = o_rid_reg;
    assign out_ch.done_valid      = o_dv_reg;
    assign out_ch.done_id         = o_did_reg;
    assign out_ch.done_turnaround = o_ta_reg;
    assign out_ch.overflow        = o_ovf_reg;

    // fill count tracks the head cell and the tail cell
    `CJS_ASSERT_IMPL(a_count_head, 1'b1, (cnt_reg == '0) == !head_valid)
    `CJS_ASSERT_IMPL(a_count_full, 1'b1, (cnt_reg == CntW'(QueueDepth)) == full)
    // a stalled result keeps the block from taking a new word
    `CJS_ASSERT_IMPL(a_no_accept_busy, out_valid_reg, !in_ch.ready)
    `CJS_ASSERT_NEXT(a_out_once, state_reg == ST_OUT, out_valid_reg)
endmodule
`default_nettype wire

>>> bench/cjs_bench_if.sv
`timescale 1ns / 1ps
// the channel interfaces of the block are used as they are; this file only
// carries the word type the bench keeps for one result
package cjs_bench_pkg;
    typedef struct packed {
        logic        running_valid;
        logic [7:0]  running_id;
        logic        done_valid;
        logic [7:0]  done_id;
        logic [15:0] done_turnaround;
        logic        overflow;
    } sched_result_t;
endpackage

>>> bench/tb_cpu_job_scheduler_unit.sv
`timescale 1ns / 1ps
module tb_cpu_job_scheduler_unit
    import cjs_pkg::*;
    import cjs_bench_pkg::*;
();

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    cjs_in_if in_ch ();
    cjs_out_if out_ch ();

    cpu_job_scheduler_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch.sink),
        .out_ch   (out_ch.source),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // scheduler shadow state
    job_t        ready_jobs[QueueDepth];
    int          ready_count;
    job_t        core_job;
    bit          core_busy;
    int          slice_ticks;
    logic [1:0]  sh_policy;
    bit          sh_qen;
    bit          sh_pen;
    logic [7:0]  sh_qlen;

    sched_result_t pending_results[$];
    int          error_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_cycles;

    // insert in policy order, equal keys keep arrival order
    function automatic bit ready_insert(job_t j);
        int pos;
        pos = ready_count;
        if (ready_count >= QueueDepth)
            return 1'b0;
        for (int i = 0; i < ready_count; i++)
        begin
            if (sh_policy == POLICY_PRIO && j.prio > ready_jobs[i].prio)
            begin
                pos = i;
                break;
            end
            if (sh_policy == POLICY_SJF && j.dur < ready_jobs[i].dur)
            begin
                pos = i;
                break;
            end
        end
        for (int i = ready_count; i > pos; i--)
            ready_jobs[i] = ready_jobs[i - 1];
        ready_jobs[pos] = j;
        ready_count++;
        return 1'b1;
    endfunction

    function automatic job_t ready_pop();
        job_t h;
        h = ready_jobs[0];
        for (int i = 1; i < ready_count; i++)
            ready_jobs[i - 1] = ready_jobs[i];
        ready_count--;
        return h;
    endfunction

    function automatic logic [15:0] age_up(logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // compute the result word of one accepted input word
    function automatic sched_result_t schedule_word(logic op, logic [7:0] id,
                                                    logic [15:0] dur, logic [7:0] prio);
        sched_result_t r;
        job_t j;
        job_t old;
        r = '0;
        if (op == OP_ARRIVE)
        begin
            j = '{id: id, prio: prio, dur: dur, rem: dur, age: 16'd0};
            r.overflow = !ready_insert(j);
            return r;
        end
        // dispatch or preempt
        if (!core_busy)
        begin
            if (ready_count > 0)
            begin
                core_job = ready_pop();
                core_busy = 1'b1;
                slice_ticks = 0;
            end
        end
        else if (sh_pen && ready_count > 0 && ready_jobs[0].prio > core_job.prio)
        begin
            old = core_job;
            core_job = ready_pop();
            slice_ticks = 0;
            void'(ready_insert(old));
        end
        if (core_busy)
        begin
            r.running_valid = 1'b1;
            r.running_id = core_job.id;
        end
        // age everything
        for (int i = 0; i < ready_count; i++)
            ready_jobs[i].age = age_up(ready_jobs[i].age);
        if (core_busy)
        begin
            core_job.age = age_up(core_job.age);
            if (core_job.rem > 0)
                core_job.rem--;
            if (slice_ticks < 255)
                slice_ticks++;
            // retire, else requeue on expired slice
            if (core_job.rem == 0)
            begin
                r.done_valid = 1'b1;
                r.done_id = core_job.id;
                r.done_turnaround = core_job.age;
                core_busy = 1'b0;
                slice_ticks = 0;
            end
            else if (sh_qen && slice_ticks >= sh_qlen)
            begin
                if (ready_insert(core_job))
                    core_busy = 1'b0;
                slice_ticks = 0;
            end
        end
        return r;
    endfunction

    // sender: drives one word, waits for acceptance, then the result is predicted
    task automatic send_word(logic op, logic [7:0] id, logic [15:0] dur, logic [7:0] prio);
        do
            @(negedge clk);
        while ($urandom_range(99) < send_idle_pct);
        in_ch.valid <= 1'b1;
        in_ch.opcode <= op;
        in_ch.job_id <= id;
        in_ch.duration <= dur;
        in_ch.job_priority <= prio;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        pending_results.insert(pending_results.size(), schedule_word(op, id, dur, prio));
        @(negedge clk);
        in_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    // register write, only while idle
    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        unique case (idx)
            REG_POLICY: sh_policy = val[1:0];
            REG_QEN:    sh_qen = val[0];
            REG_PEN:    sh_pen = val[0];
            REG_QLEN:   sh_qlen = val;
        endcase
    endtask

    task automatic set_mode(logic [1:0] pol, bit qen, bit pen, logic [7:0] qlen);
        write_reg(REG_POLICY, 8'(pol));
        write_reg(REG_QEN, 8'(qen));
        write_reg(REG_PEN, 8'(pen));
        write_reg(REG_QLEN, qlen);
    endtask

    // receiver: random stall, long hold-offs on request
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // checker: compare each result word with the oldest prediction
    always @(posedge clk)
    begin
        sched_result_t got;
        sched_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = '{out_ch.running_valid, out_ch.running_id, out_ch.done_valid,
                    out_ch.done_id, out_ch.done_turnaround, out_ch.overflow};
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result word %h", got);
            end
            else
            begin
                want = pending_results[0];
                pending_results.delete(0);
                if (got !== want)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch: expected run %b/%0d done %b/%0d/%0d ovf %b,",
                                 want.running_valid, want.running_id, want.done_valid,
                                 want.done_id, want.done_turnaround, want.overflow,
                                 " got run %b/%0d done %b/%0d/%0d ovf %b",
                                 got.running_valid, got.running_id, got.done_valid,
                                 got.done_id, got.done_turnaround, got.overflow);
                end
            end
        end
    end

    // directed table; expect_known marks rows whose result is typed in
    typedef struct {
        logic        op;
        logic [7:0]  id;
        logic [15:0] dur;
        logic [7:0]  prio;
        bit          expect_known;
        sched_result_t result;
    } dir_row_t;

    dir_row_t dir_rows[] = '{
        // tick on an empty core after reset
        '{OP_TICK, 8'hFF, 16'hFFFF, 8'hFF, 1, '{0, 8'd0, 0, 8'd0, 16'd0, 0}},
        '{OP_ARRIVE, 8'd0, 16'd1, 8'd0, 1, '0},
        // duration one job runs and finishes in one tick
        '{OP_TICK, 8'd0, 16'd0, 8'd0, 1, '{1, 8'd0, 1, 8'd0, 16'd1, 0}},
        '{OP_ARRIVE, 8'hFF, 16'hFFFF, 8'hFF, 1, '0},
        // zero duration acts like one
        '{OP_ARRIVE, 8'd7, 16'd0, 8'd3, 1, '0},
        '{OP_TICK, 8'd0, 16'd0, 8'd0, 1, '{1, 8'hFF, 0, 8'd0, 16'd0, 0}},
        '{OP_ARRIVE, 8'd9, 16'd2, 8'd200, 0, '0},
        '{OP_TICK, 8'd0, 16'd0, 8'd0, 0, '0},
        '{OP_TICK, 8'd0, 16'd0, 8'd0, 0, '0},
        '{OP_TICK, 8'd0, 16'd0, 8'd0, 0, '0}
    };

    task automatic random_phase(int count, int idle_pct, int stall_pct);
        logic op;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++)
        begin
            op = ($urandom_range(99) < 55) ? OP_TICK : OP_ARRIVE;
            send_word(op, 8'($urandom_range(255)),
                      ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(6)),
                      ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                               : 8'($urandom_range(3)));
        end
    endtask

    // run time limit
    initial
    begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        sched_result_t want;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_TICK;
        in_ch.job_id = '0;
        in_ch.duration = '0;
        in_ch.job_priority = '0;
        out_ch.ready = 1'b0;
        hold_cycles = 0;
        error_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        ready_count = 0;
        core_busy = 1'b0;
        core_job = '0;
        slice_ticks = 0;
        sh_policy = POLICY_FIFO;
        sh_qen = 1'b0;
        sh_pen = 1'b0;
        sh_qlen = 8'd2;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part: typed rows are checked against the table as well
        foreach (dir_rows[k])
        begin
            send_word(dir_rows[k].op, dir_rows[k].id, dir_rows[k].dur, dir_rows[k].prio);
            want = pending_results[$];
            if (dir_rows[k].expect_known && want !== dir_rows[k].result)
            begin
                error_count++;
                $display("table row %0d disagrees with prediction", k);
            end
        end
        // fill past full to see overflow
        for (int k = 0; k < QueueDepth + 2; k++)
            send_word(OP_ARRIVE, 8'(k), 16'd3, 8'(k));
        drain();

        // long receiver hold-off while words keep coming
        hold_cycles = 200;
        random_phase(40, 0, 0);
        // sender pause until all results are in
        drain();

        set_mode(POLICY_PRIO, 1, 1, 8'd1);
        random_phase(300, 0, 0);
        set_mode(POLICY_SJF, 1, 0, 8'd255);
        random_phase(300, 46, 0);
        set_mode(2'd3, 0, 1, 8'd0);
        random_phase(300, 0, 46);
        set_mode(POLICY_FIFO, 1, 1, 8'd3);
        random_phase(300, 31, 31);
        set_mode(POLICY_PRIO, 1, 1, 8'd2);
        random_phase(300, 0, 0);

        recv_stall_pct = 0;
        drain();
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

>>> sim.f
+incdir+rtl
rtl/cjs_pkg.sv
rtl/cjs_if.sv
rtl/cjs_cell.sv
rtl/cjs_queue.sv
rtl/cpu_job_scheduler_unit.sv
bench/cjs_bench_if.sv
bench/tb_cpu_job_scheduler_unit.sv
